// File: sv/brlp_pkg.sv
`timescale 1ns / 1ps
// Package for the bit range list parser: payload structs, character classes,
// mask operations and shared constants. Depends on nothing.
package brlp_pkg;

	localparam int unsigned MASK_W = 64;
	localparam int unsigned BIT_W  = 6;
	localparam int unsigned NUM_W  = 7;

	localparam logic [NUM_W-1:0] NUM_SAT = 7'd64;

	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] bit_mask;
		logic              range_error;
	} out_item_t;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_PLUS,
		CLS_MINUS,
		CLS_COMMA,
		CLS_DIGIT,
		CLS_OTHER
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [3:0]  digit;
		logic        last;
	} token_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_TOGGLE,
		OP_RANGE
	} op_kind_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [BIT_W-1:0] lo;
		logic [BIT_W-1:0] hi;
		logic             last;
		logic             err;
	} mask_op_t;

	// Two shifted left by n, with the top case wrapping to zero.
	function automatic logic [MASK_W-1:0] two_shifted(input logic [BIT_W-1:0] n);
		logic [MASK_W-1:0] r;
		if (n == 6'd63) begin
			r = '0;
		end else begin
			r = 64'd2 << n;
		end
		return r;
	endfunction

endpackage

// File: sv/bit_range_list_parser.sv
`timescale 1ns / 1ps
// Top level of the bit range list parser: front end, token queue and back end.
// Depends on brlp_pkg, brlp_front, brlp_queue and brlp_back.
// The block takes one character per cycle while the output is not stalled;
// the parser stage then consumes one queued character per cycle and sets that
// rate. The result passes the token queue, the parser stage register and the
// result register after the character marked last is taken, and the next
// string may follow at once. Stalls on the output fill the queue (QUEUE_DEPTH
// entries) before the input is held off.
module bit_range_list_parser #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  brlp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output brlp_pkg::out_item_t out_data
);
	import brlp_pkg::*;

	token_t tok;
	token_t head;
	logic   full;
	logic   nonempty;
	logic   pop;

	assign in_ready = !full;

	brlp_front u_front (
		.in_item (in_data),
		.tok     (tok)
	);

	brlp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !full),
		.push_data (tok),
		.full      (full),
		.pop       (pop),
		.nonempty  (nonempty),
		.head      (head)
	);

	brlp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (nonempty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// File: sv/brlp_front.sv
`timescale 1ns / 1ps
// Front end of the bit range list parser: sorts each incoming character into
// a class and keeps its digit value. Depends on brlp_pkg.
module brlp_front (
	input  brlp_pkg::in_item_t in_item,
	output brlp_pkg::token_t   tok
);
	import brlp_pkg::*;

	logic is_digit;
	logic is_space;

	assign is_digit = (in_item.text_byte >= CHAR_ZERO) && (in_item.text_byte <= CHAR_NINE);
	assign is_space = (in_item.text_byte == CHAR_SPACE) ||
		((in_item.text_byte >= CHAR_TAB) && (in_item.text_byte <= CHAR_CR));

	always_comb begin
		tok.digit = in_item.text_byte[3:0];
		tok.last  = in_item.is_last;
		if (is_space) begin
			tok.cls = CLS_SPACE;
		end else if (is_digit) begin
			tok.cls = CLS_DIGIT;
		end else if (in_item.text_byte == CHAR_PLUS) begin
			tok.cls = CLS_PLUS;
		end else if (in_item.text_byte == CHAR_MINUS) begin
			tok.cls = CLS_MINUS;
		end else if (in_item.text_byte == CHAR_COMMA) begin
			tok.cls = CLS_COMMA;
		end else begin
			tok.cls = CLS_OTHER;
		end
	end

endmodule

// File: sv/brlp_queue.sv
`timescale 1ns / 1ps
// Short token queue between the front end and the parser.
// Depends on brlp_pkg for the token type.
module brlp_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  brlp_pkg::token_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              nonempty,
	output brlp_pkg::token_t  head
);
	import brlp_pkg::*;

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	token_t             mem_q [DEPTH];
	logic [IDX_W-1:0]   wr_ptr_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/brlp_back.sv
`timescale 1ns / 1ps
// Back end of the bit range list parser: the number parser stage, then the
// mask stage with the result register. Depends on brlp_pkg.
module brlp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  brlp_pkg::token_t    head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output brlp_pkg::out_item_t out_data
);
	import brlp_pkg::*;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_SIGN_POS,
		PH_SIGN_NEG,
		PH_DIG_POS,
		PH_DIG_NEG,
		PH_STOP
	} phase_t;

	phase_t            phase_q, ph_n, start_ph;
	logic [NUM_W-1:0]  num_q, num_n;
	logic [BIT_W-1:0]  rs_q, rs_n;
	logic              rp_q, rp_n;
	logic              err_q, err_n;
	mask_op_t          op_s1, op_n;
	logic              op_valid_s1;
	logic              emit;
	logic              fin, fin_neg, fin_ok, open_range;
	logic [NUM_W-1:0]  fin_val;
	logic [10:0]       acc_wide;
	logic              op_take;
	logic [MASK_W-1:0] mask_q, term, mask_new;
	logic              out_valid_q;
	out_item_t         out_q;

	assign acc_wide = ({4'd0, num_q} << 3) + ({4'd0, num_q} << 1) + {7'd0, head.digit};

	always_comb begin
		case (head.cls)
			CLS_SPACE: start_ph = PH_SKIP;
			CLS_PLUS:  start_ph = PH_SIGN_POS;
			CLS_MINUS: start_ph = PH_SIGN_NEG;
			CLS_DIGIT: start_ph = PH_DIG_POS;
			default:   start_ph = PH_STOP;
		endcase
	end

	always_comb begin
		ph_n       = phase_q;
		num_n      = num_q;
		rs_n       = rs_q;
		rp_n       = rp_q;
		err_n      = err_q;
		fin        = 1'b0;
		fin_val    = num_q;
		fin_neg    = (phase_q == PH_DIG_NEG);
		open_range = 1'b0;
		case (phase_q)
			PH_SKIP: begin
				ph_n = start_ph;
				if (head.cls == CLS_DIGIT) begin
					num_n = {3'd0, head.digit};
				end
			end
			PH_SIGN_POS, PH_SIGN_NEG: begin
				if (head.cls == CLS_DIGIT) begin
					num_n = {3'd0, head.digit};
					ph_n  = (phase_q == PH_SIGN_POS) ? PH_DIG_POS : PH_DIG_NEG;
				end else begin
					ph_n = PH_STOP;
				end
			end
			PH_DIG_POS, PH_DIG_NEG: begin
				if (head.cls == CLS_DIGIT) begin
					num_n = (acc_wide > {4'd0, NUM_SAT}) ? NUM_SAT : acc_wide[NUM_W-1:0];
				end else begin
					fin   = 1'b1;
					num_n = '0;
					if (head.cls == CLS_COMMA) begin
						ph_n = PH_SKIP;
					end else if (head.cls == CLS_MINUS) begin
						open_range = 1'b1;
						ph_n       = PH_SKIP;
					end else begin
						ph_n = start_ph;
					end
				end
			end
			default: begin
				ph_n = PH_STOP;
			end
		endcase

		// A number still open at the closing character is completed here.
		if (head.last && (ph_n == PH_DIG_POS || ph_n == PH_DIG_NEG)) begin
			fin     = 1'b1;
			fin_val = num_n;
			fin_neg = (ph_n == PH_DIG_NEG);
		end

		fin_ok = !(fin_neg && fin_val != '0) && (fin_val < NUM_SAT);

		op_n.kind = OP_NONE;
		op_n.lo   = rs_q;
		op_n.hi   = fin_val[BIT_W-1:0];
		op_n.last = head.last;
		if (fin) begin
			rp_n = 1'b0;
			if (!fin_ok) begin
				err_n = 1'b1;
			end else begin
				op_n.kind = rp_q ? OP_RANGE : OP_TOGGLE;
			end
		end
		if (open_range && fin_ok) begin
			rs_n = fin_val[BIT_W-1:0];
			rp_n = 1'b1;
		end
		op_n.err = err_n;
		emit     = head.last || (op_n.kind != OP_NONE);
	end

	assign op_take = op_valid_s1 && (!op_s1.last || !out_valid_q || out_ready);
	assign pop     = head_valid && (!op_valid_s1 || op_take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			num_q       <= '0;
			rs_q        <= '0;
			rp_q        <= 1'b0;
			err_q       <= 1'b0;
			op_valid_s1 <= 1'b0;
			op_s1       <= '0;
		end else if (pop) begin
			if (head.last) begin
				phase_q <= PH_SKIP;
				num_q   <= '0;
				rs_q    <= '0;
				rp_q    <= 1'b0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= ph_n;
				num_q   <= num_n;
				rs_q    <= rs_n;
				rp_q    <= rp_n;
				err_q   <= err_n;
			end
			op_valid_s1 <= emit;
			op_s1       <= op_n;
		end else if (op_take) begin
			op_valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		case (op_s1.kind)
			OP_TOGGLE: term = 64'd1 << op_s1.hi;
			OP_RANGE:  term = two_shifted(op_s1.hi) - two_shifted(op_s1.lo);
			default:   term = '0;
		endcase
		mask_new = mask_q ^ term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op_take) begin
				mask_q <= op_s1.last ? '0 : mask_new;
			end
			if (op_take && op_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_take && op_s1.last) begin
			out_q.bit_mask    <= mask_new;
			out_q.range_error <= op_s1.err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: sv/brlp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bit range list parser, bound to the top level.
// Depends on brlp_pkg.
module brlp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input brlp_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input brlp_pkg::out_item_t out_data
);
	import brlp_pkg::*;

	logic [7:0] pending_q;
	logic       last_in;
	logic       res_out;

	assign last_in = in_valid && in_ready && in_data.is_last;
	assign res_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !res_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_out && !last_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped before its transfer");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("result offered without a closing character");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("input held off without a preceding transfer");

	a_fresh_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pending_q != 8'd0) || $past(last_in))
		else $error("result raised with nothing outstanding");

endmodule

bind bit_range_list_parser brlp_checker u_brlp_checker (.*);
